>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define AST_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication: ante holds, then cons holds.
`define AST_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: ante holds, then cons holds.
`define AST_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/kil_pkg.sv
// Package for the keyword/identifier lexer: token kinds, keyword table,
// byte codes and the result word layout. No dependencies.
package kil_pkg;

    typedef enum logic [2:0] {
        KIND_KEYWORD = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_PUNCT   = 3'd2,
        KIND_OPER    = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    localparam int KW_COUNT = 6;

    // Keyword text, first byte in the lowest byte, unused bytes zero
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_006C_6562_616C,   // label
        64'h0068_7061_7267_6964,   // digraph
        64'h0000_0054_5550_4E49,   // INPUT
        64'h0000_5455_5054_554F,   // OUTPUT
        64'h0000_0000_3244_4E41,   // AND2
        64'h0000_0000_3252_4F58    // XOR2
    };
    localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd5, 8'd7, 8'd5, 8'd6, 8'd4, 8'd4};

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_GREATER    = 8'h3E;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    localparam logic [15:0] LINE_OUT_MAX = 16'hFFFF;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] text;
        logic [7:0]  length;
        logic [15:0] line;
        logic        last;
    } token_t;

    function automatic logic is_word_byte(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]}) ||
               (c inside {[8'h30:8'h39]}) || (c == CH_UNDERSCORE);
    endfunction

endpackage

>>> rtl/core/keyword_identifier_lexer.sv
// Keyword/identifier lexer top level: byte-serial tokenizer with output queue.
// Depends on kil_pkg and assert_macros.svh.
//
// Usage:
//   The slave channel (s_*) takes one text byte per word. Runs of letters,
//   digits and underscore build a word that is emitted when any other byte
//   ends it; it is tagged keyword or identifier. Brackets, braces, quote and
//   semicolon give punctuation tokens, = - > give operator tokens, space and
//   NUL are dropped, byte 10 bumps the line count, anything else is an error
//   token. One byte gives zero, one or two tokens; tlast marks the final token
//   a byte caused.
//   The master channel (m_*) carries one token per word from a 4-entry queue.
//   With an empty queue a byte's first token is on m_* the cycle after the
//   byte is accepted; a second token of the same byte follows it.
//   Throughput: one byte per cycle while s_tready is high, set by the queue
//   drain of one token per cycle; a byte that yields two tokens queues both.
//   s_tready is high while the queue holds at most two tokens, so the two
//   tokens of one byte always fit; a stalled receiver stops the input once
//   three or more tokens wait, and nothing is lost.
//   Reset (rst_n low, async) empties the queue, closes any open word and sets
//   the line count to 1.
`include "assert_macros.svh"

module keyword_identifier_lexer
    import kil_pkg::*;
#(
    parameter int MAX_CHARS = 8,     // word bytes kept, 7..8
    parameter int LINE_BITS = 16     // line counter width, 8..32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,     // [63:0] text, [71:64] length, [87:72] line
    output logic [2:0]  m_tuser,     // [2:0] kind
    output logic        m_tlast      // last token of this input byte
);

    localparam int TEXT_W = 8 * MAX_CHARS;
    localparam int DEPTH  = 4;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Open word and line state
    logic [TEXT_W-1:0]    word_text_reg, word_text_next;
    logic [7:0]           word_len_reg, word_len_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [15:0]          line_out;

    // Output queue
    token_t           fifo_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_inc;
    logic [CNT_W-1:0] count_reg;
    logic [1:0]       push_n;
    logic             pop;
    token_t           slot0, slot1, head;

    // Decode of the incoming byte
    logic       accept;
    logic       is_word;
    logic       has_sym;
    kind_t      sym_kind;
    logic       kw_hit;
    logic       word_open;
    token_t     word_tok, sym_tok;

    // Line shown on tokens saturates at 16 bits
    generate
        if (LINE_BITS > 16) begin : g_line_wide
            assign line_out = (|line_reg[LINE_BITS-1:16]) ? LINE_OUT_MAX : line_reg[15:0];
        end else begin : g_line_narrow
            assign line_out = 16'(line_reg);
        end
    endgenerate

    assign accept    = s_tvalid & s_tready;
    assign is_word   = is_word_byte(s_tdata);
    assign word_open = (word_len_reg != 8'd0);

    always_comb
    begin
        has_sym  = 1'b1;
        sym_kind = KIND_ERROR;
        if (s_tdata inside {CH_LBRACKET, CH_LBRACE, CH_RBRACKET, CH_RBRACE, CH_QUOTE, CH_SEMI})
        begin
            sym_kind = KIND_PUNCT;
        end
        else if (s_tdata inside {CH_EQUAL, CH_MINUS, CH_GREATER})
        begin
            sym_kind = KIND_OPER;
        end
        else if (s_tdata inside {CH_NEWLINE, CH_NUL, CH_SPACE})
        begin
            has_sym = 1'b0;
        end
    end

    always_comb
    begin
        kw_hit = 1'b0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (word_len_reg == KW_LEN[k] && 64'(word_text_reg) == KW_TEXT[k])
            begin
                kw_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        word_tok.kind   = kw_hit ? KIND_KEYWORD : KIND_IDENT;
        word_tok.text   = 64'(word_text_reg);
        word_tok.length = word_len_reg;
        word_tok.line   = line_out;
        word_tok.last   = ~has_sym;

        sym_tok.kind    = sym_kind;
        sym_tok.text    = 64'(s_tdata);
        sym_tok.length  = 8'd1;
        sym_tok.line    = line_out;
        sym_tok.last    = 1'b1;
    end

    // Next state of the word and line registers, plus queue writes
    always_comb
    begin
        word_text_next = word_text_reg;
        word_len_next  = word_len_reg;
        line_next      = line_reg;
        slot0          = sym_tok;
        slot1          = sym_tok;
        push_n         = 2'd0;
        if (accept)
        begin
            if (is_word)
            begin
                for (int i = 0; i < MAX_CHARS; i++)
                begin
                    if (word_len_reg == 8'(i))
                    begin
                        word_text_next[8*i +: 8] = s_tdata;
                    end
                end
                if (word_len_reg != 8'hFF)
                begin
                    word_len_next = word_len_reg + 8'd1;
                end
            end
            else
            begin
                if (word_open)
                begin
                    slot0          = word_tok;
                    push_n         = has_sym ? 2'd2 : 2'd1;
                    word_text_next = '0;
                    word_len_next  = 8'd0;
                end
                else
                begin
                    push_n = {1'b0, has_sym};
                end
                if (s_tdata == CH_NEWLINE && !(&line_reg))
                begin
                    line_next = line_reg + LINE_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_text_reg <= '0;
            word_len_reg  <= 8'd0;
            line_reg      <= LINE_BITS'(1);
        end
        else
        begin
            word_text_reg <= word_text_next;
            word_len_reg  <= word_len_next;
            line_reg      <= line_next;
        end
    end

    // Queue: up to two writes and one read per cycle
    assign wr_ptr_inc = wr_ptr_reg + PTR_W'(1);
    assign pop        = m_tvalid & m_tready;
    assign s_tready   = (count_reg <= CNT_W'(DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= slot0;
        end
        if (push_n == 2'd2)
        begin
            fifo_mem[wr_ptr_inc] <= slot1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {head.line, head.length, head.text};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    // Checks
    `AST_ALWAYS(a_fifo_bound, count_reg <= CNT_W'(DEPTH), "token queue overfilled")
    `AST_IMPLY(a_word_first_byte, word_len_reg != 8'd0, word_text_reg[7:0] != 8'd0, "open word has empty first byte")
    `AST_NEXT(a_line_step, accept && s_tdata == CH_NEWLINE && !(&line_reg), line_reg == LINE_BITS'($past(line_reg) + LINE_BITS'(1)), "line count did not advance")

endmodule
